// ===== src/lcdnib_pkg.sv =====
// shared types and constants for the character lcd nibble interface
`timescale 1ns / 1ps

package lcdnib_pkg;

    // request function codes
    localparam logic [2:0] FUNC_DATA   = 3'd0;
    localparam logic [2:0] FUNC_CMD    = 3'd1;
    localparam logic [2:0] FUNC_CURSOR = 3'd2;
    localparam logic [2:0] FUNC_CLEAR  = 3'd3;
    localparam logic [2:0] FUNC_HOME   = 3'd4;
    localparam logic [2:0] FUNC_INIT   = 3'd5;

    // configuration register indexes
    localparam logic REG_ENABLE_PULSE = 1'b0;
    localparam logic REG_BYTE_SETTLE  = 1'b1;

    localparam int CFG_DATA_W = 10;
    localparam int STEP_IDX_W = 5;

    localparam logic [7:0]  PULSE_RESET  = 8'd20;
    localparam logic [9:0]  SETTLE_RESET = 10'd75;
    localparam logic [15:0] LONG_WAIT_US = 16'd15000;
    localparam logic [15:0] POWER_UP_US  = 16'd42000;

    localparam logic [7:0] CURSOR_BASE = 8'h80;
    localparam logic [7:0] CODE_CLEAR  = 8'h01;
    localparam logic [7:0] CODE_HOME   = 8'h02;

    // final step index of a plain byte run and of the init run
    localparam logic [STEP_IDX_W-1:0] LAST_BYTE_IDX = 5'd3;
    localparam logic [STEP_IDX_W-1:0] LAST_INIT_IDX = 5'd24;
    localparam logic [STEP_IDX_W-1:0] INIT_NIB_IDX  = 5'd1;
    localparam logic [STEP_IDX_W-1:0] INIT_BYTE_IDX = 5'd9;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] value;
        logic [7:0] col;
        logic [2:0] row;
    } lcdnib_req_t;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        reg_select;
        logic        enable;
        logic [15:0] hold_us;
        logic        last;
    } lcdnib_step_t;

    // controller to datapath
    typedef struct packed {
        logic                  load_req;
        logic                  load_out;
        logic [STEP_IDX_W-1:0] idx;
        logic                  last;
    } lcdnib_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic no_steps;
        logic init_seq;
    } lcdnib_status_t;

    function automatic logic [7:0] row_base(input logic [1:0] r);
        logic [7:0] b;
        case (r)
            2'd0: b = 8'h00;
            2'd1: b = 8'h40;
            2'd2: b = 8'h10;
            default: b = 8'h50;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] init_wait(input logic [1:0] k);
        logic [15:0] w;
        case (k)
            2'd0: w = 16'd5000;
            2'd1: w = 16'd1000;
            2'd2: w = 16'd1000;
            default: w = 16'd3000;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] init_byte(input logic [1:0] j);
        logic [7:0] b;
        case (j)
            2'd0: b = 8'h2C;
            2'd1: b = 8'h0C;
            2'd2: b = 8'h06;
            default: b = CODE_CLEAR;
        endcase
        return b;
    endfunction

endpackage

// ===== src/lcdnib_ctrl.sv =====
// sequencer that walks the pin steps of one request
`timescale 1ns / 1ps

module lcdnib_ctrl
    import lcdnib_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  lcdnib_status_t status,
    output lcdnib_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                  state_reg, state_next;
    logic [STEP_IDX_W-1:0] idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  slot_free;
    logic                  last_step;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign slot_free = !out_valid_reg || m_ready;
    assign last_step = (idx_reg == (status.init_seq ? LAST_INIT_IDX : LAST_BYTE_IDX));

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd.load_req = 1'b0;
        cmd.load_out = 1'b0;
        cmd.idx      = idx_reg;
        cmd.last     = last_step;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    idx_next     = '0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.no_steps) begin
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    cmd.load_out = 1'b1;
                    if (last_step) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/lcdnib_dp.sv =====
// request and timing registers, step decode and output register
`timescale 1ns / 1ps

module lcdnib_dp
    import lcdnib_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  lcdnib_req_t           s_req,
    input  lcdnib_cmd_t           cmd,
    output lcdnib_status_t        status,
    output lcdnib_step_t          m_step
);

    logic [7:0]   pulse_reg;
    logic [9:0]   settle_reg;
    lcdnib_req_t  req_reg;
    lcdnib_step_t step_reg, step_next;

    logic [7:0]            byte_val;
    logic                  rs;
    logic                  long_wait;
    logic [1:0]            sub;
    logic [STEP_IDX_W-1:0] i_nib, i_byte;
    logic [15:0]           pulse_w, settle_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg  <= PULSE_RESET;
            settle_reg <= SETTLE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ENABLE_PULSE: pulse_reg  <= cfg_wdata[7:0];
                REG_BYTE_SETTLE:  settle_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_req;
        end
        if (cmd.load_out) begin
            step_reg <= step_next;
        end
    end

    assign m_step = step_reg;

    always_comb begin
        status.init_seq = (req_reg.func == FUNC_INIT);
        case (req_reg.func)
            FUNC_DATA, FUNC_CMD, FUNC_CLEAR, FUNC_HOME, FUNC_INIT: status.no_steps = 1'b0;
            FUNC_CURSOR: status.no_steps = req_reg.row[2];
            default:     status.no_steps = 1'b1;
        endcase
    end

    assign pulse_w  = {8'd0, pulse_reg};
    assign settle_w = {6'd0, settle_reg};
    assign i_nib    = cmd.idx - INIT_NIB_IDX;
    assign i_byte   = cmd.idx - INIT_BYTE_IDX;

    // pick the byte being sent and its sub-step within the byte
    always_comb begin
        byte_val  = req_reg.value;
        rs        = 1'b0;
        long_wait = 1'b0;
        sub       = cmd.idx[1:0];
        unique case (req_reg.func)
            FUNC_DATA: rs = 1'b1;
            FUNC_CURSOR: byte_val = CURSOR_BASE + row_base(req_reg.row[1:0]) + req_reg.col;
            FUNC_CLEAR: begin
                byte_val  = CODE_CLEAR;
                long_wait = 1'b1;
            end
            FUNC_HOME: begin
                byte_val  = CODE_HOME;
                long_wait = 1'b1;
            end
            FUNC_INIT: begin
                byte_val  = init_byte(i_byte[3:2]);
                long_wait = (i_byte[3:2] == 2'd3);
                sub       = i_byte[1:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        step_next.reg_select = rs;
        step_next.last       = cmd.last;
        step_next.nibble     = sub[1] ? byte_val[3:0] : byte_val[7:4];
        step_next.enable     = !sub[0];
        if (!sub[0]) begin
            step_next.hold_us = pulse_w;
        end else if (!sub[1]) begin
            step_next.hold_us = '0;
        end else if (long_wait) begin
            step_next.hold_us = settle_w + LONG_WAIT_US;
        end else begin
            step_next.hold_us = settle_w;
        end
        // power-up wait and the bare init nibbles
        if (status.init_seq && cmd.idx < INIT_BYTE_IDX) begin
            if (cmd.idx == '0) begin
                step_next.nibble  = 4'h0;
                step_next.enable  = 1'b0;
                step_next.hold_us = POWER_UP_US;
            end else begin
                step_next.nibble  = (i_nib[2:1] == 2'd3) ? 4'h2 : 4'h3;
                step_next.enable  = !i_nib[0];
                step_next.hold_us = i_nib[0] ? init_wait(i_nib[2:1]) : pulse_w;
            end
        end
    end

endmodule

// ===== src/char_lcd_nibble_interface_core.sv =====
// top level of the 4-bit character lcd interface
`timescale 1ns / 1ps

// usage:
// a request (data, command, set cursor, clear, home, init) is a transfer on
// s_valid/s_ready carrying s_req. each request expands to a run of pin steps
// sent as transfers on m_valid/m_ready carrying m_step, with last set on the
// final step. byte requests give 4 steps, init gives 25, a cursor request with
// row above 3 or an unknown function gives none.
// the request is held in a request register and each step is registered in
// the output register that drives m_valid/m_step.
// throughput: one step per cycle while m_ready is high; s_ready is low while
// the step sequencer runs. the output register lets the next request be
// taken while the last step still waits for the receiver.
// a stall on m_ready holds the current step and pauses the sequencer.
// timing registers (0: enable pulse us, 1: byte settle us) are written via
// cfg_we/cfg_index/cfg_wdata, by the user only while idle; the block does not
// enforce this. reset restores 20 and 75 us and drops any pending request or
// step.
module char_lcd_nibble_interface_core
    import lcdnib_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lcdnib_req_t           s_req,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lcdnib_step_t          m_step
);

    lcdnib_cmd_t    cmd;
    lcdnib_status_t status;

    lcdnib_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lcdnib_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_req     (s_req),
        .cmd       (cmd),
        .status    (status),
        .m_step    (m_step)
    );

endmodule

// ===== tb/lcdnib_sb_pkg.sv =====
// scoreboard class that predicts and checks the lcd pin steps
`timescale 1ns / 1ps

package lcdnib_sb_pkg;
    import lcdnib_pkg::*;

    // function codes that the block does not implement
    localparam logic [2:0] FUNC_BAD_LO = 3'd6;
    localparam logic [2:0] FUNC_BAD_HI = 3'd7;
    localparam logic [2:0] ROW_MAX     = 3'd3;

    localparam int unsigned MAX_PRINTED = 40;

    class lcd_step_scoreboard;
        logic [7:0]   pulse_us;
        logic [9:0]   settle_us;
        lcdnib_step_t step_q[$];
        int unsigned  errors;
        int unsigned  requests;
        int unsigned  steps_checked;

        function new();
            pulse_us      = PULSE_RESET;
            settle_us     = SETTLE_RESET;
            errors        = 0;
            requests      = 0;
            steps_checked = 0;
        endfunction

        // register writes keep only the register's own width
        function void set_reg(logic idx, logic [CFG_DATA_W-1:0] d);
            if (idx == REG_ENABLE_PULSE) begin
                pulse_us = d[7:0];
            end else begin
                settle_us = d[9:0];
            end
        endfunction

        function int pending();
            return step_q.size();
        endfunction

        function void push_step(logic [3:0] nib, logic rs, logic en, logic [15:0] hold);
            lcdnib_step_t s;
            s.nibble     = nib;
            s.reg_select = rs;
            s.enable     = en;
            s.hold_us    = hold;
            s.last       = 1'b0;
            step_q.push_back(s);
        endfunction

        // high nibble first, each nibble strobed, settle after the low one
        function void push_byte(logic [7:0] b, logic rs);
            push_step(b[7:4], rs, 1'b1, {8'd0, pulse_us});
            push_step(b[7:4], rs, 1'b0, 16'd0);
            push_step(b[3:0], rs, 1'b1, {8'd0, pulse_us});
            push_step(b[3:0], rs, 1'b0, {6'd0, settle_us});
        endfunction

        function void push_long_cmd(logic [7:0] code);
            push_byte(code, 1'b0);
            step_q[step_q.size()-1].hold_us = {6'd0, settle_us} + LONG_WAIT_US;
        endfunction

        function void push_init_nibble(logic [3:0] nib, logic [15:0] wait_us);
            push_step(nib, 1'b0, 1'b1, {8'd0, pulse_us});
            push_step(nib, 1'b0, 1'b0, wait_us);
        endfunction

        function void note_request(lcdnib_req_t r);
            int         before_n;
            logic [7:0] base;
            before_n = step_q.size();
            requests++;
            case (r.func)
                FUNC_DATA: push_byte(r.value, 1'b1);
                FUNC_CMD: push_byte(r.value, 1'b0);
                FUNC_CURSOR: begin
                    if (r.row <= ROW_MAX) begin
                        case (r.row[1:0])
                            2'd0: base = 8'h00;
                            2'd1: base = 8'h40;
                            2'd2: base = 8'h10;
                            default: base = 8'h50;
                        endcase
                        push_byte(8'h80 + base + r.col, 1'b0);
                    end
                end
                FUNC_CLEAR: push_long_cmd(8'h01);
                FUNC_HOME: push_long_cmd(8'h02);
                FUNC_INIT: begin
                    push_step(4'h0, 1'b0, 1'b0, 16'd42000);
                    push_init_nibble(4'h3, 16'd5000);
                    push_init_nibble(4'h3, 16'd1000);
                    push_init_nibble(4'h3, 16'd1000);
                    push_init_nibble(4'h2, 16'd3000);
                    push_byte(8'h2C, 1'b0);
                    push_byte(8'h0C, 1'b0);
                    push_byte(8'h06, 1'b0);
                    push_long_cmd(8'h01);
                end
                default: ;
            endcase
            if (step_q.size() > before_n) begin
                step_q[step_q.size()-1].last = 1'b1;
            end
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            errors++;
        endtask

        task check_step(lcdnib_step_t got);
            lcdnib_step_t e;
            if (step_q.size() == 0) begin
                report($sformatf("step %h with nothing expected", got));
            end else begin
                e = step_q.pop_front();
                steps_checked++;
                if (got.nibble !== e.nibble)
                    report($sformatf("nibble %h, expected %h", got.nibble, e.nibble));
                if (got.reg_select !== e.reg_select)
                    report($sformatf("reg_select %b, expected %b",
                                     got.reg_select, e.reg_select));
                if (got.enable !== e.enable)
                    report($sformatf("enable %b, expected %b", got.enable, e.enable));
                if (got.hold_us !== e.hold_us)
                    report($sformatf("hold_us %0d, expected %0d", got.hold_us, e.hold_us));
                if (got.last !== e.last)
                    report($sformatf("last %b, expected %b", got.last, e.last));
            end
        endtask
    endclass

endpackage

// ===== tb/tb_top.sv =====
// top level testbench for the character lcd nibble interface
`timescale 1ns / 1ps

module tb_top;
    import lcdnib_pkg::*;
    import lcdnib_sb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          SETTLE_CYCLES = 20;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    lcdnib_req_t           s_req = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    lcdnib_step_t          m_step;

    logic        quiet = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycle_cnt = 0;
    int unsigned settings_run = 1;

    lcd_step_scoreboard sb;

    char_lcd_nibble_interface_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_step    (m_step)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("char_lcd_nibble_interface_core regression: fail");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_step(m_step);
        end
    end

    function automatic lcdnib_req_t mk_req(logic [2:0] f, logic [7:0] v, logic [7:0] c,
                                           logic [2:0] r);
        lcdnib_req_t q;
        q.func  = f;
        q.value = v;
        q.col   = c;
        q.row   = r;
        return q;
    endfunction

    function automatic lcdnib_req_t rand_request();
        lcdnib_req_t q;
        int          pick;
        q.value = 8'($urandom);
        q.col   = 8'($urandom);
        q.row   = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(4, 7))
                                              : 3'($urandom_range(0, 3));
        pick = $urandom_range(0, 39);
        if (pick < 12)      q.func = FUNC_DATA;
        else if (pick < 20) q.func = FUNC_CMD;
        else if (pick < 30) q.func = FUNC_CURSOR;
        else if (pick < 33) q.func = FUNC_CLEAR;
        else if (pick < 36) q.func = FUNC_HOME;
        else if (pick < 38) q.func = FUNC_INIT;
        else if (pick == 38) q.func = FUNC_BAD_LO;
        else                q.func = FUNC_BAD_HI;
        return q;
    endfunction

    // valid stays up between back-to-back transfers; a gap lowers it once
    task automatic send_req(input lcdnib_req_t r);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
    endtask

    // sender idle until every predicted step has been seen
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_timing(input logic [CFG_DATA_W-1:0] pulse,
                              input logic [CFG_DATA_W-1:0] settle);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ENABLE_PULSE;
        cfg_wdata <= pulse;
        @(posedge aclk);
        sb.set_reg(REG_ENABLE_PULSE, pulse);
        cfg_index <= REG_BYTE_SETTLE;
        cfg_wdata <= settle;
        @(posedge aclk);
        sb.set_reg(REG_BYTE_SETTLE, settle);
        cfg_we <= 1'b0;
        @(posedge aclk);
        settings_run++;
    endtask

    task automatic run_random(input int n, input bit hold_off);
        for (int i = 0; i < n; i++) begin
            if (hold_off && i == n / 2) drain();
            send_req(rand_request());
        end
        drain();
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed part at reset timing
        send_req(mk_req(FUNC_DATA,   8'h00, 8'h00, 3'd0));
        send_req(mk_req(FUNC_DATA,   8'hFF, 8'hFF, 3'd7));
        send_req(mk_req(FUNC_CMD,    8'h5A, 8'h00, 3'd0));
        send_req(mk_req(FUNC_CMD,    8'hA5, 8'h00, 3'd0));
        send_req(mk_req(FUNC_CURSOR, 8'h00, 8'h00, 3'd0));
        send_req(mk_req(FUNC_CURSOR, 8'hFF, 8'hFF, 3'd1));
        send_req(mk_req(FUNC_CURSOR, 8'h00, 8'h7F, 3'd2));
        send_req(mk_req(FUNC_CURSOR, 8'h00, 8'hAF, 3'd3));
        // rows past the last give no steps
        send_req(mk_req(FUNC_CURSOR, 8'h12, 8'h05, 3'd4));
        send_req(mk_req(FUNC_CURSOR, 8'h12, 8'hFF, 3'd7));
        send_req(mk_req(FUNC_BAD_LO, 8'hFF, 8'hFF, 3'd7));
        send_req(mk_req(FUNC_BAD_HI, 8'h00, 8'h00, 3'd0));
        send_req(mk_req(FUNC_CLEAR,  8'h00, 8'h00, 3'd0));
        send_req(mk_req(FUNC_HOME,   8'hFF, 8'hFF, 3'd7));
        send_req(mk_req(FUNC_INIT,   8'h00, 8'h00, 3'd0));
        send_req(mk_req(FUNC_DATA,   8'h0F, 8'hF0, 3'd3));
        drain();

        // zero timing registers pass straight through
        set_timing(10'd0, 10'd0);
        send_req(mk_req(FUNC_DATA,  8'hC3, 8'h00, 3'd0));
        send_req(mk_req(FUNC_CLEAR, 8'h00, 8'h00, 3'd0));
        send_req(mk_req(FUNC_INIT,  8'h00, 8'h00, 3'd0));
        run_random(12, 1'b0);

        set_timing(10'd255, 10'd1023);
        send_req(mk_req(FUNC_HOME, 8'h00, 8'h00, 3'd0));
        run_random(16, 1'b1);

        // upper bits beyond the pulse register are dropped
        set_timing(10'h3A5, 10'($urandom_range(1, 1023)));
        run_random(16, 1'b0);

        set_timing(10'd1, 10'd1);
        run_random(16, 1'b0);

        set_timing(10'($urandom_range(1, 255)), 10'($urandom_range(1, 1023)));
        run_random(16, 1'b0);

        // closing stretch at full rate on both sides
        quiet <= 1'b1;
        set_timing(10'($urandom_range(1, 255)), 10'($urandom_range(1, 1023)));
        run_random(20, 1'b0);

        $display("run covered %0d requests and %0d pin steps over %0d timing settings",
                 sb.requests, sb.steps_checked, settings_run);
        $display("directed extremes, all functions, bad rows and codes, zero and masked timing");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("char_lcd_nibble_interface_core regression: pass");
        end else begin
            $display("char_lcd_nibble_interface_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/lcdnib_pkg.sv
src/lcdnib_ctrl.sv
src/lcdnib_dp.sv
src/char_lcd_nibble_interface_core.sv
tb/lcdnib_sb_pkg.sv
tb/tb_top.sv
